FILE: rtl/swmm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding-window min/max index package
// Shared widths, types and the scan control bundle.
// ----------------------------------------------------------------------------
package swmm_pkg;

	localparam int WINDOW_MAX = 64;
	localparam int PTR_W      = $clog2(WINDOW_MAX);
	localparam int LEN_W      = 7;
	localparam int DATA_W     = 32;
	localparam int IDX_W      = 32;
	localparam int CFG_W      = 32;

	localparam logic CFG_WINDOW_LENGTH = 1'b0;
	localparam logic CFG_FIRST_INDEX   = 1'b1;

	localparam logic [LEN_W-1:0] WINDOW_LENGTH_RESET = LEN_W'(30);

	typedef logic signed [DATA_W-1:0] sample_t;
	typedef logic [IDX_W-1:0]         index_t;
	typedef logic [PTR_W-1:0]         ptr_t;

	typedef struct packed {
		logic   valid;
		logic   first;
		index_t position;
	} scan_ctl_t;

endpackage

FILE: rtl/swmm_ring.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sample ring memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module swmm_ring (
	input  logic           clk,
	input  logic           wr_en,
	input  swmm_pkg::ptr_t wr_addr,
	input  swmm_pkg::sample_t wr_data,
	input  logic           rd_en,
	input  swmm_pkg::ptr_t rd_addr,
	output swmm_pkg::sample_t rd_data
);
	import swmm_pkg::*;

	sample_t mem [0:WINDOW_MAX-1];
	sample_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: rtl/swmm_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Window scan unit
// Walks the window oldest first and keeps the strict maximum and minimum.
// ----------------------------------------------------------------------------
module swmm_scan (
	input  logic                 clk,
	input  swmm_pkg::scan_ctl_t  ctl,
	input  swmm_pkg::sample_t    data,
	output swmm_pkg::sample_t    hi_value,
	output swmm_pkg::index_t     hi_position,
	output swmm_pkg::sample_t    lo_value,
	output swmm_pkg::index_t     lo_position
);
	import swmm_pkg::*;

	sample_t hi_value_q;
	sample_t lo_value_q;
	index_t  hi_position_q;
	index_t  lo_position_q;

	always_ff @(posedge clk) begin
		if (ctl.valid) begin
			if (ctl.first || (data > hi_value_q)) begin
				hi_value_q    <= data;
				hi_position_q <= ctl.position;
			end
			if (ctl.first || (data < lo_value_q)) begin
				lo_value_q    <= data;
				lo_position_q <= ctl.position;
			end
		end
	end

	assign hi_value    = hi_value_q;
	assign hi_position = hi_position_q;
	assign lo_value    = lo_value_q;
	assign lo_position = lo_position_q;

endmodule

FILE: rtl/sliding_window_min_max_index.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding-window min/max index
// Reports the absolute indices of the window maximum and minimum per sample.
// ----------------------------------------------------------------------------
// An accepted item hands its result to the output register from the done state,
// where the result waits while a previous result is still stalled. When the
// current maximum or minimum falls out of the window or is not yet known, the
// ring memory is read back one entry per cycle over the whole window, and the
// drain and apply states follow before the done state. The first
// window_length - 1 samples of a series give no result, and the block starts
// a new series after a sample marked end_of_series. A new item is accepted
// while the previous result still waits in the output register.
module sliding_window_min_max_index (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic                      cfg_addr,
	input  logic [swmm_pkg::CFG_W-1:0] cfg_wdata,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  swmm_pkg::sample_t         sample,
	input  logic                      end_of_series,
	output logic                      out_valid,
	input  logic                      out_stall,
	output swmm_pkg::index_t          min_index,
	output swmm_pkg::index_t          max_index,
	output swmm_pkg::index_t          current_index,
	output logic                      is_last
);
	import swmm_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SCAN  = 3'd1;
	localparam logic [2:0] ST_DRAIN = 3'd2;
	localparam logic [2:0] ST_APPLY = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	logic [2:0]       state_q;
	logic [LEN_W-1:0] win_len_q;
	index_t           first_index_q;

	ptr_t             wp_q;
	logic [LEN_W-1:0] seen_q;
	index_t           next_index_q;
	sample_t          hi_value_q;
	sample_t          lo_value_q;
	index_t           hi_pos_q;
	index_t           lo_pos_q;
	logic             hi_valid_q;
	logic             lo_valid_q;

	index_t           today_q;
	index_t           oldest_q;
	ptr_t             back_q;
	ptr_t             start_q;
	ptr_t             k_q;
	ptr_t             k_s1;
	logic             rd_valid_s1;
	logic             last_q;
	logic             produce_q;
	logic             hi_scan_q;
	logic             lo_scan_q;

	logic             out_valid_q;
	index_t           min_index_q;
	index_t           max_index_q;
	index_t           current_index_q;
	logic             is_last_q;

	logic             accept;
	logic [LEN_W-1:0] len_c;
	ptr_t             back_c;
	index_t           today_c;
	logic [LEN_W-1:0] seen_c;
	logic             produce_c;
	logic             hi_stale_c;
	logic             lo_stale_c;
	logic             out_free;
	logic             out_load;

	scan_ctl_t        scan_ctl;
	sample_t          rd_data;
	sample_t          scan_hi_value;
	sample_t          scan_lo_value;
	index_t           scan_hi_pos;
	index_t           scan_lo_pos;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign out_load = (state_q == ST_DONE) && produce_q && out_free;

	always_comb begin
		if (win_len_q == '0) begin
			len_c = LEN_W'(1);
		end else if (win_len_q > LEN_W'(WINDOW_MAX)) begin
			len_c = LEN_W'(WINDOW_MAX);
		end else begin
			len_c = win_len_q;
		end
		back_c     = PTR_W'(len_c - LEN_W'(1));
		today_c    = (seen_q == '0) ? first_index_q : next_index_q;
		seen_c     = (seen_q < LEN_W'(WINDOW_MAX)) ? seen_q + LEN_W'(1) : seen_q;
		produce_c  = (seen_c >= len_c);
		hi_stale_c = !hi_valid_q || ((today_c - hi_pos_q) > IDX_W'(back_c));
		lo_stale_c = !lo_valid_q || ((today_c - lo_pos_q) > IDX_W'(back_c));
	end

	assign scan_ctl = '{
		valid:    rd_valid_s1,
		first:    (k_s1 == '0),
		position: oldest_q + IDX_W'(k_s1)
	};

	swmm_ring u_ring (
		.clk     (clk),
		.wr_en   (accept),
		.wr_addr (wp_q),
		.wr_data (sample),
		.rd_en   (state_q == ST_SCAN),
		.rd_addr (start_q + k_q),
		.rd_data (rd_data)
	);

	swmm_scan u_scan (
		.clk         (clk),
		.ctl         (scan_ctl),
		.data        (rd_data),
		.hi_value    (scan_hi_value),
		.hi_position (scan_hi_pos),
		.lo_value    (scan_lo_value),
		.lo_position (scan_lo_pos)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_len_q     <= WINDOW_LENGTH_RESET;
			first_index_q <= '0;
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_WINDOW_LENGTH: win_len_q     <= cfg_wdata[LEN_W-1:0];
				CFG_FIRST_INDEX:   first_index_q <= cfg_wdata[IDX_W-1:0];
				default:           ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			today_q   <= today_c;
			oldest_q  <= today_c - IDX_W'(back_c);
			back_q    <= back_c;
			start_q   <= wp_q - back_c;
			last_q    <= end_of_series;
			produce_q <= produce_c;
			hi_scan_q <= hi_stale_c;
			lo_scan_q <= lo_stale_c;
		end
		k_s1 <= k_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			wp_q         <= '0;
			seen_q       <= '0;
			next_index_q <= '0;
			hi_value_q   <= '0;
			lo_value_q   <= '0;
			hi_pos_q     <= '0;
			lo_pos_q     <= '0;
			hi_valid_q   <= 1'b0;
			lo_valid_q   <= 1'b0;
			k_q          <= '0;
			rd_valid_s1  <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			rd_valid_s1 <= (state_q == ST_SCAN);
			out_valid_q <= out_load || (out_valid_q && out_stall);
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						wp_q         <= wp_q + PTR_W'(1);
						seen_q       <= seen_c;
						next_index_q <= today_c + IDX_W'(1);
						k_q          <= '0;
						if (produce_c) begin
							if (!hi_stale_c && (sample >= hi_value_q)) begin
								hi_value_q <= sample;
								hi_pos_q   <= today_c;
							end
							if (!lo_stale_c && (sample <= lo_value_q)) begin
								lo_value_q <= sample;
								lo_pos_q   <= today_c;
							end
							state_q <= (hi_stale_c || lo_stale_c) ? ST_SCAN : ST_DONE;
						end else begin
							hi_valid_q <= 1'b0;
							lo_valid_q <= 1'b0;
							state_q    <= ST_DONE;
						end
					end
				end
				ST_SCAN: begin
					k_q <= k_q + PTR_W'(1);
					if (k_q == back_q) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_APPLY;
				end
				ST_APPLY: begin
					if (hi_scan_q) begin
						hi_value_q <= scan_hi_value;
						hi_pos_q   <= scan_hi_pos;
						hi_valid_q <= 1'b1;
					end
					if (lo_scan_q) begin
						lo_value_q <= scan_lo_value;
						lo_pos_q   <= scan_lo_pos;
						lo_valid_q <= 1'b1;
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!produce_q || out_free) begin
						if (last_q) begin
							seen_q     <= '0;
							hi_value_q <= '0;
							lo_value_q <= '0;
							hi_pos_q   <= '0;
							lo_pos_q   <= '0;
							hi_valid_q <= 1'b0;
							lo_valid_q <= 1'b0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			min_index_q     <= lo_pos_q;
			max_index_q     <= hi_pos_q;
			current_index_q <= today_q;
			is_last_q       <= last_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign min_index     = min_index_q;
	assign max_index     = max_index_q;
	assign current_index = current_index_q;
	assign is_last       = is_last_q;

endmodule
